// ===== hdl/cfd_pkg.sv =====
package cfd_pkg;

  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CountW-1:0] MinFrameBytes = 17'd9;
  localparam logic [CountW-1:0] PayloadStart = 17'd7;
  localparam logic [CountW-1:0] FirstEmitIdx = PayloadStart + 17'd1;

  // Byte positions of the fixed fields
  localparam logic [CountW-1:0] IdxHeader = 17'd0;
  localparam logic [CountW-1:0] IdxSeqLast = 17'd2;
  localparam logic [CountW-1:0] IdxCmdLast = 17'd4;
  localparam logic [CountW-1:0] IdxLenLast = 17'd6;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_BAD_HDR   = 3'd2,
    VERDICT_BAD_SUM   = 3'd3,
    VERDICT_BAD_LEN   = 3'd4
  } verdict_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_offset;
    verdict_e    verdict;
    logic [15:0] sequence_number;
    logic [15:0] command_code;
    logic [15:0] declared_length;
  } result_t;

endpackage

// ===== hdl/cfd_frame_core.sv =====
module cfd_frame_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            accept_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output logic            res_valid_o,
  output cfd_pkg::result_t res_o
);

  logic [7:0]                   exp_hdr_q;
  logic [cfd_pkg::CountW-1:0]   count_q, count_d;
  logic [15:0]                  sum_q, sum_d;
  logic [7:0]                   recent_q, recent_d;
  logic [7:0]                   older_q, older_d;
  logic                         hdr_ok_q, hdr_ok_d;
  logic [15:0]                  seq_q, seq_d;
  logic [15:0]                  cmd_q, cmd_d;
  logic [15:0]                  len_q, len_d;

  logic [15:0]                  seq_cap, cmd_cap, len_cap;
  logic                         hdr_ok_cap;
  logic [15:0]                  sum_next;
  logic                         emit;
  logic [cfd_pkg::CountW-1:0]   off_full;
  logic [15:0]                  offset;
  logic [cfd_pkg::CountW-1:0]   count_inc;
  logic [cfd_pkg::CountW-1:0]   total;
  logic [15:0]                  rx_sum;
  cfd_pkg::verdict_e            verdict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_hdr_q <= '0;
    end else if (cfg_we_i) begin
      exp_hdr_q <= cfg_data_i;
    end
  end

  // Field capture for the byte at hand
  always_comb begin
    hdr_ok_cap = hdr_ok_q;
    seq_cap    = seq_q;
    cmd_cap    = cmd_q;
    len_cap    = len_q;
    if (count_q == cfd_pkg::IdxHeader) begin
      hdr_ok_cap = (byte_i == exp_hdr_q);
    end else if (count_q <= cfd_pkg::IdxSeqLast) begin
      seq_cap = {seq_q[7:0], byte_i};
    end else if (count_q <= cfd_pkg::IdxCmdLast) begin
      cmd_cap = {cmd_q[7:0], byte_i};
    end else if (count_q <= cfd_pkg::IdxLenLast) begin
      len_cap = {len_q[7:0], byte_i};
    end
  end

  assign sum_next  = (count_q >= cfd_pkg::IdxSeqLast) ? sum_q + {8'd0, older_q} : sum_q;
  assign count_inc = (count_q != cfd_pkg::CountMax) ? count_q + 1'b1 : count_q;
  assign total     = count_inc;
  assign rx_sum    = {recent_q, byte_i};
  assign emit      = (count_q >= cfd_pkg::FirstEmitIdx);
  assign off_full  = count_q - cfd_pkg::FirstEmitIdx;
  assign offset    = off_full[cfd_pkg::CountW-1] ? 16'hFFFF : off_full[15:0];

  always_comb begin
    priority if (total < cfd_pkg::MinFrameBytes) begin
      verdict = cfd_pkg::VERDICT_SHORT;
    end else if (!hdr_ok_cap) begin
      verdict = cfd_pkg::VERDICT_BAD_HDR;
    end else if (sum_next != rx_sum) begin
      verdict = cfd_pkg::VERDICT_BAD_SUM;
    end else if ({1'b0, len_cap} != (total - cfd_pkg::MinFrameBytes)) begin
      verdict = cfd_pkg::VERDICT_BAD_LEN;
    end else begin
      verdict = cfd_pkg::VERDICT_OK;
    end
  end

  always_comb begin
    res_valid_o = accept_i && (last_i || emit);
    res_o       = '0;
    if (last_i) begin
      res_o.kind            = cfd_pkg::KIND_VERDICT;
      res_o.verdict         = verdict;
      res_o.sequence_number = seq_cap;
      res_o.command_code    = cmd_cap;
      res_o.declared_length = len_cap;
    end else begin
      res_o.kind           = cfd_pkg::KIND_PAYLOAD;
      res_o.payload_byte   = recent_q;
      res_o.payload_offset = offset;
      res_o.verdict        = cfd_pkg::VERDICT_OK;
    end
  end

  always_comb begin
    count_d  = count_q;
    sum_d    = sum_q;
    recent_d = recent_q;
    older_d  = older_q;
    hdr_ok_d = hdr_ok_q;
    seq_d    = seq_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    if (accept_i) begin
      if (last_i) begin
        // clear for the next frame
        count_d  = '0;
        sum_d    = '0;
        recent_d = '0;
        older_d  = '0;
        hdr_ok_d = 1'b0;
        seq_d    = '0;
        cmd_d    = '0;
        len_d    = '0;
      end else begin
        count_d  = count_inc;
        sum_d    = sum_next;
        recent_d = byte_i;
        older_d  = recent_q;
        hdr_ok_d = hdr_ok_cap;
        seq_d    = seq_cap;
        cmd_d    = cmd_cap;
        len_d    = len_cap;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_q    <= '0;
      recent_q <= '0;
      older_q  <= '0;
      hdr_ok_q <= 1'b0;
      seq_q    <= '0;
      cmd_q    <= '0;
      len_q    <= '0;
    end else begin
      count_q  <= count_d;
      sum_q    <= sum_d;
      recent_q <= recent_d;
      older_q  <= older_d;
      hdr_ok_q <= hdr_ok_d;
      seq_q    <= seq_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
    end
  end

endmodule

// ===== hdl/cfd_out_skid.sv =====
module cfd_out_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  cfd_pkg::result_t in_res_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output cfd_pkg::result_t out_res_o,
  input  logic             out_ready_i
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  cfd_pkg::result_t out_q, out_d;
  cfd_pkg::result_t skid_q, skid_d;
  logic             out_free;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // drain the skid entry first
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_valid_i;
        out_d       = in_res_i;
      end
    end else if (in_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = in_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// ===== hdl/command_frame_deframer.sv =====
// Channel  | Dir | Signals                          | Item
// ---------+-----+----------------------------------+------------------------------
// s_axis   | in  | tvalid tready tdata[7:0] tlast   | one frame byte, tlast on last
// m_axis   | out | tvalid tready tdata[79:0] tuser  | payload byte or frame verdict
// cfg      | in  | cfg_we_i cfg_data_i[7:0]         | expected header byte
//
// One input item per cycle while s_axis_tready_o is high; each result is formed
// when a byte is accepted and is registered in the output buffer. The per-byte
// work is one 16-bit add and a few compares feeding the output register.
// Reset clears all frame state and sets the expected header to zero.
// A two-entry output buffer (output register plus skid) decouples the sides:
// s_axis_tready_o drops only while both entries hold results.
module command_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  logic        s_axis_tlast_i,   // frame_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] payload_byte, [23:8] payload_offset, [26:24] verdict,
  // [42:27] sequence_number, [58:43] command_code, [74:59] declared_length,
  // [79:75] zero
  output logic [79:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o    // result_kind: 0 payload, 1 verdict
);

  logic             accept;
  logic             res_valid;
  cfd_pkg::result_t res;
  cfd_pkg::result_t out_res;

  // An item enters the core whenever the skid entry is free
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  cfd_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cfd_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_res_i    (res),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_res_o   (out_res),
    .out_ready_i (m_axis_tready_i)
  );

  // Pack the result fields, highest field first
  assign m_axis_tdata_o = {
    5'd0,
    out_res.declared_length,
    out_res.command_code,
    out_res.sequence_number,
    out_res.verdict,
    out_res.payload_offset,
    out_res.payload_byte
  };
  assign m_axis_tuser_o = out_res.kind;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  typedef logic [7:0] octet_q_t [$];

  // Ways to spoil an otherwise well-formed frame
  typedef enum int {
    FLAW_NONE,
    FLAW_HEADER,
    FLAW_SUM,
    FLAW_LEN
  } flaw_e;

  // One result as seen on m_axis, unpacked
  typedef struct {
    cfd_pkg::kind_e    kind;
    logic [7:0]        pbyte;
    logic [15:0]       poff;
    cfd_pkg::verdict_e verdict;
    logic [15:0]       seq;
    logic [15:0]       cmd;
    logic [15:0]       dlen;
  } outcome_t;

  // Tracks the deframer state per accepted byte and checks results in order.
  class deframe_checker;
    logic [7:0]  want_header;
    logic [16:0] frame_cnt;
    logic [15:0] lag_sum;
    logic [7:0]  newest;
    logic [7:0]  older;
    bit          hdr_match;
    logic [15:0] seq;
    logic [15:0] cmd;
    logic [15:0] dlen;
    outcome_t    awaited [$];
    int          errors;

    function new();
      want_header = 8'h00;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      frame_cnt = '0;
      lag_sum = '0;
      newest = '0;
      older = '0;
      hdr_match = 1'b0;
      seq = '0;
      cmd = '0;
      dlen = '0;
    endfunction

    function void set_header(logic [7:0] h);
      want_header = h;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void note_byte(logic [7:0] b, bit fin);
      logic [16:0] pos;
      logic [16:0] total;
      logic [16:0] rel;
      logic [7:0]  prev;
      outcome_t    o;
      pos = frame_cnt;
      if (pos == cfd_pkg::IdxHeader) begin
        hdr_match = (b == want_header);
      end else if (pos <= cfd_pkg::IdxSeqLast) begin
        seq = {seq[7:0], b};
      end else if (pos <= cfd_pkg::IdxCmdLast) begin
        cmd = {cmd[7:0], b};
      end else if (pos <= cfd_pkg::IdxLenLast) begin
        dlen = {dlen[7:0], b};
      end
      // The sum trails by two bytes so the checksum itself never enters it
      if (pos >= 17'd2) lag_sum = lag_sum + older;
      prev = newest;
      older = newest;
      newest = b;
      o.kind = cfd_pkg::KIND_PAYLOAD;
      o.pbyte = '0;
      o.poff = '0;
      o.verdict = cfd_pkg::VERDICT_OK;
      o.seq = '0;
      o.cmd = '0;
      o.dlen = '0;
      if (!fin) begin
        if (frame_cnt != cfd_pkg::CountMax) frame_cnt++;
        // The byte before this one is known to be payload now
        if (pos >= cfd_pkg::FirstEmitIdx) begin
          rel = pos - cfd_pkg::FirstEmitIdx;
          o.poff = (rel > 17'h0ffff) ? 16'hffff : rel[15:0];
          o.pbyte = prev;
          awaited.push_back(o);
        end
      end else begin
        total = (frame_cnt != cfd_pkg::CountMax) ? frame_cnt + 17'd1 : cfd_pkg::CountMax;
        o.kind = cfd_pkg::KIND_VERDICT;
        if (total < cfd_pkg::MinFrameBytes) begin
          o.verdict = cfd_pkg::VERDICT_SHORT;
        end else if (!hdr_match) begin
          o.verdict = cfd_pkg::VERDICT_BAD_HDR;
        end else if (lag_sum != {older, newest}) begin
          o.verdict = cfd_pkg::VERDICT_BAD_SUM;
        end else if ({1'b0, dlen} != total - cfd_pkg::MinFrameBytes) begin
          o.verdict = cfd_pkg::VERDICT_BAD_LEN;
        end else begin
          o.verdict = cfd_pkg::VERDICT_OK;
        end
        o.seq = seq;
        o.cmd = cmd;
        o.dlen = dlen;
        awaited.push_back(o);
        clear_frame();
      end
    endfunction

    function void check_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic tuser, logic [79:0] tdata);
      outcome_t o;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, kind %b data %h", $time, tuser, tdata);
        errors++;
        return;
      end
      o = awaited.pop_front();
      check_field("kind", 16'(o.kind), 16'(tuser));
      check_field("payload_byte", 16'(o.pbyte), 16'(tdata[7:0]));
      check_field("payload_offset", o.poff, tdata[23:8]);
      check_field("verdict", 16'(o.verdict), 16'(tdata[26:24]));
      check_field("sequence_number", o.seq, tdata[42:27]);
      check_field("command_code", o.cmd, tdata[58:43]);
      check_field("declared_length", o.dlen, tdata[74:59]);
      check_field("pad", 16'h0000, 16'(tdata[79:75]));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [7:0]  cfg_data;
  logic        s_axis_tvalid;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tready;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;

  deframe_checker sb = new();

  // Idling knobs, percent of cycles; rx_hold forces a long receiver stall
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  int bytes_sent = 0;

  command_frame_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop: end the run with a failure if it has not finished
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: check each accepted result, then pick next cycle's tready.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tuser, m_axis_tdata);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one byte, idling first at random; return once it is accepted.
  // tvalid stays high afterward so back-to-back bytes never toggle it.
  task automatic send_byte(logic [7:0] b, bit fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_frame(octet_q_t fr);
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
  endtask

  // Drop tvalid and hold until every awaited result is back, plus a margin
  // for the output buffer.
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_header(logic [7:0] h);
    wait_results();
    cfg_we <= 1'b1;
    cfg_data <= h;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_header(h);
  endtask

  // Build a frame with a correct checksum unless told to spoil a part of it.
  function automatic octet_q_t make_frame(logic [7:0] hdr, int plen, flaw_e flaw);
    octet_q_t    fr;
    logic [15:0] seq;
    logic [15:0] cmd;
    logic [15:0] dlen;
    logic [15:0] csum;
    seq = 16'($urandom);
    cmd = 16'($urandom);
    dlen = plen[15:0];
    if (flaw == FLAW_LEN) dlen = dlen ^ (16'd1 << $urandom_range(15));
    fr.push_back((flaw == FLAW_HEADER) ? hdr ^ 8'($urandom_range(1, 255)) : hdr);
    fr.push_back(seq[15:8]);
    fr.push_back(seq[7:0]);
    fr.push_back(cmd[15:8]);
    fr.push_back(cmd[7:0]);
    fr.push_back(dlen[15:8]);
    fr.push_back(dlen[7:0]);
    repeat (plen) fr.push_back(8'($urandom));
    csum = '0;
    foreach (fr[i]) csum = csum + fr[i];
    if (flaw == FLAW_SUM) csum = csum ^ 16'($urandom_range(1, 65535));
    fr.push_back(csum[15:8]);
    fr.push_back(csum[7:0]);
    return fr;
  endfunction

  // A random mix of well-formed frames, frames with a flawed header, checksum
  // or length, truncated frames and plain noise bursts.
  task automatic run_random(int budget, logic [7:0] hdr);
    int       start;
    int       r;
    int       plen;
    int       cut;
    octet_q_t fr;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      r = $urandom_range(99);
      plen = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
      if (r < 70) begin
        fr = make_frame(hdr, plen,
                        (r < 45) ? FLAW_NONE : flaw_e'($urandom_range(FLAW_HEADER, FLAW_LEN)));
      end else if (r < 85) begin
        fr = make_frame(hdr, plen, FLAW_NONE);
        cut = $urandom_range(fr.size() - 2);
        fr = fr[0:cut];
      end else begin
        fr.delete();
        repeat ($urandom_range(1, 12)) fr.push_back(8'($urandom));
      end
      send_frame(fr);
    end
  endtask

  initial begin
    octet_q_t fr;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= 8'h00;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 8'h00;
    s_axis_tlast <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at full rate, header 0x00
    program_header(8'h00);
    fr = {8'h00};                           // lone end byte: too short, fields zero
    send_frame(fr);
    fr = {8'h01, 8'h12, 8'h34, 8'h56};      // short wins over bad header
    send_frame(fr);
    fr = {8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};  // one byte short
    send_frame(fr);
    send_frame(make_frame(8'h00, 0, FLAW_NONE));   // minimal frame, empty payload
    send_frame(make_frame(8'h00, 3, FLAW_NONE));
    send_frame(make_frame(8'h00, 1, FLAW_HEADER));
    send_frame(make_frame(8'h00, 2, FLAW_SUM));
    send_frame(make_frame(8'h00, 1, FLAW_LEN));
    fr = make_frame(8'h00, 1, FLAW_HEADER);         // bad header ranks above bad sum
    fr[fr.size() - 1] = fr[fr.size() - 1] ^ 8'h01;
    send_frame(fr);

    program_header(8'hff);
    send_frame(make_frame(8'hff, 2, FLAW_NONE));
    fr = make_frame(8'h00, 0, FLAW_NONE);            // header matches the old setting only
    send_frame(fr);

    // No idling; stall the receiver long enough to back up the input
    run_random(90, 8'hff);
    rx_hold = 300;
    run_random(100, 8'hff);

    // Sender mostly idle; pause once until everything is back
    wait_results();
    tx_idle_pct = 87;
    rx_stall_pct = 0;
    program_header(8'($urandom));
    run_random(90, sb.want_header);
    wait_results();
    run_random(100, sb.want_header);

    // Receiver mostly stalled
    tx_idle_pct = 0;
    rx_stall_pct = 87;
    program_header(8'h00);
    run_random(170, 8'h00);

    // Both sides idle now and then
    tx_idle_pct = 11;
    rx_stall_pct = 11;
    program_header(8'($urandom));
    run_random(170, sb.want_header);

    wait_results();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
